// File: hw/rtl/u8pc_pkg.sv
// Shared types and constants for the printable UTF-8 text checker.
`default_nettype none

package u8pc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned PendW = 2;

    localparam logic [ByteW-1:0] PRINT_MIN    = 8'h21;
    localparam logic [ByteW-1:0] ASCII_DEL    = 8'h7F;
    localparam logic [ByteW-1:0] ASCII_TOP    = 8'h80;
    localparam logic [ByteW-1:0] LEAD2_MIN    = 8'hC2;
    localparam logic [ByteW-1:0] LEAD2_MAX    = 8'hDF;
    localparam logic [ByteW-1:0] LEAD3_MIN    = 8'hE0;
    localparam logic [ByteW-1:0] LEAD3_SURR   = 8'hED;
    localparam logic [ByteW-1:0] LEAD3_MAX    = 8'hEF;
    localparam logic [ByteW-1:0] LEAD4_MIN    = 8'hF0;
    localparam logic [ByteW-1:0] LEAD4_MAX    = 8'hF4;
    localparam logic [ByteW-1:0] CONT_A0      = 8'hA0;
    localparam logic [ByteW-1:0] CONT_90      = 8'h90;
    localparam logic [ByteW-1:0] CONT_MASK    = 8'hC0;
    localparam logic [ByteW-1:0] CONT_PATTERN = 8'h80;

    // extra bound on the first continuation byte after certain leads
    typedef enum logic [2:0] {
        BOUND_NONE     = 3'd0,
        BOUND_MIN_A0   = 3'd1,
        BOUND_BELOW_A0 = 3'd2,
        BOUND_MIN_90   = 3'd3,
        BOUND_BELOW_90 = 3'd4
    } bound_t;

    typedef struct packed {
        logic [PendW-1:0] pend;
        bound_t           bound;
        logic             err;
    } parse_state_t;

    // one byte held in the input stage
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
        logic             last;
    } in_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/utf8_printable_text_checker.sv
// Top level of the printable UTF-8 text checker.
//
// Slave stream: one text byte per beat in s_tdata, s_tlast on the final byte
// of a text. Master stream: one verdict beat per text, m_tdata[0] = 1 when the
// whole text is well-formed UTF-8 of visible characters only (no ASCII controls,
// space or DEL; no overlongs, surrogates or code points above U+10FFFF; no
// sequence left open at the end).
// A byte is registered on acceptance, parsed in the next cycle against the
// running sequence state, and the verdict of a final byte is registered in the
// result stage, which drives m_tvalid.
// Bytes go through at one byte per cycle while the receiver does not stall; the
// parse step between the input register and the result register is combinational.
// Bytes that are not final produce no beat and never wait on the master side.
// When the receiver stalls, a final byte waits in the input register while one
// verdict sits in the result register, and s_tready drops only then.
// Reset empties both registers and clears the sequence state; no text is open.
`default_nettype none

module utf8_printable_text_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] text_valid, [7:1] zero
);
    import u8pc_pkg::*;

    in_beat_t     beat;
    parse_state_t state;
    logic         advance;
    logic         verdict;
    logic         can_load;
    logic         res_load;

    // a non-final byte never needs room in the result register
    assign advance  = beat.valid && (!beat.last || can_load);
    assign res_load = advance && beat.last;

    u8pc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .beat     (beat)
    );

    u8pc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (beat.data),
        .last_byte (beat.last),
        .advance   (advance),
        .verdict   (verdict),
        .state     (state)
    );

    u8pc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .verdict  (verdict),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a final byte leaves the sequence state cleared
    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state == parse_state_t'('0)))
        else $error("sequence state not cleared after final byte");

    // a first-byte bound only exists while a 3 or 4 byte sequence awaits its first continuation
    a_bound_pending : assert property (@(posedge clk) disable iff (!rst_n)
        (state.bound != BOUND_NONE) |-> (state.pend == 2'd2 || state.pend == 2'd3))
        else $error("first-byte bound set without an open long sequence");

    // input stage only blocks while a final byte waits behind a held verdict
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (beat.valid && beat.last && m_tvalid && !m_tready))
        else $error("input stalled without a waiting verdict");

endmodule

`default_nettype wire

// File: hw/rtl/u8pc_in_stage.sv
// Input register for incoming text beats.
`default_nettype none

module u8pc_in_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tlast,
    input  wire logic                   advance,
    output u8pc_pkg::in_beat_t          beat
);
    import u8pc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] data_reg;
    logic             last_reg;
    logic             load;

    // empty, or the held beat leaves this cycle
    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;
    assign beat.last  = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/u8pc_parse.sv
// Per-byte UTF-8 parser with the running sequence state of the current text.
`default_nettype none

module u8pc_parse (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [7:0]             text_byte,
    input  wire logic                   last_byte,
    input  wire logic                   advance,
    output logic                        verdict,
    output u8pc_pkg::parse_state_t      state
);
    import u8pc_pkg::*;

    parse_state_t state_reg;
    parse_state_t step;
    parse_state_t state_next;
    logic         bad_cont;

    always_comb
    begin
        step     = state_reg;
        bad_cont = 1'b0;
        if (state_reg.pend == '0)
        begin
            if (text_byte < ASCII_TOP)
            begin
                if (text_byte < PRINT_MIN || text_byte == ASCII_DEL)
                begin
                    step.err = 1'b1;
                end
            end
            else if (text_byte >= LEAD2_MIN && text_byte <= LEAD2_MAX)
            begin
                step.pend = 2'd1;
            end
            else if (text_byte >= LEAD3_MIN && text_byte <= LEAD3_MAX)
            begin
                step.pend = 2'd2;
                if (text_byte == LEAD3_MIN)
                begin
                    step.bound = BOUND_MIN_A0;
                end
                else if (text_byte == LEAD3_SURR)
                begin
                    step.bound = BOUND_BELOW_A0;
                end
            end
            else if (text_byte >= LEAD4_MIN && text_byte <= LEAD4_MAX)
            begin
                step.pend = 2'd3;
                if (text_byte == LEAD4_MIN)
                begin
                    step.bound = BOUND_MIN_90;
                end
                else if (text_byte == LEAD4_MAX)
                begin
                    step.bound = BOUND_BELOW_90;
                end
            end
            else
            begin
                step.err = 1'b1;
            end
        end
        else
        begin
            case (state_reg.bound)
                BOUND_MIN_A0:   bad_cont = text_byte < CONT_A0;
                BOUND_BELOW_A0: bad_cont = text_byte >= CONT_A0;
                BOUND_MIN_90:   bad_cont = text_byte < CONT_90;
                BOUND_BELOW_90: bad_cont = text_byte >= CONT_90;
                default:        bad_cont = 1'b0;
            endcase
            if ((text_byte & CONT_MASK) != CONT_PATTERN)
            begin
                bad_cont = 1'b1;
            end
            step.bound = BOUND_NONE;
            step.pend  = state_reg.pend - 2'd1;
            if (bad_cont)
            begin
                step.err = 1'b1;
            end
        end
    end

    assign verdict = !step.err && (step.pend == '0);

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            // the final byte hands over its verdict and clears for the next text
            state_next = last_byte ? parse_state_t'('0) : step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// File: hw/rtl/u8pc_out_stage.sv
// Result register holding one verdict beat until the receiver takes it.
`default_nettype none

module u8pc_out_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic       verdict,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata
);
    import u8pc_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic verdict_reg;

    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(ByteW-1){1'b0}}, verdict_reg};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Stream testbench for the printable UTF-8 text checker: directed and random texts.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u8pc_pkg::*;

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    localparam int unsigned NumBytes   = 1700;
    localparam int unsigned IdlePct    = 8;
    localparam int unsigned CalmStart  = 400;
    localparam int unsigned CalmEnd    = 1100;
    localparam int unsigned StallLimit = 2000;
    localparam int unsigned Drain      = 10;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    utf8_printable_text_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // bytes waiting to go out, verdicts waiting to come back
    text_beat_t  pending_bytes[$];
    logic        verdict_q[$];

    // parse state of the text currently being sent
    logic [1:0]  seq_pend  = '0;
    bound_t      seq_bound = BOUND_NONE;
    logic        seq_err   = 1'b0;

    int unsigned cyc           = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned bytes_sent    = 0;
    int unsigned verdicts_seen = 0;
    int unsigned good_texts    = 0;
    int unsigned mismatches    = 0;
    logic        go;

    initial begin
        forever #4 clk = ~clk;
    end

    // no idling in the calm window
    function automatic logic take_break();
        return !(cyc >= CalmStart && cyc < CalmEnd) && ($urandom_range(99) < IdlePct);
    endfunction

    // advance the parse state by one accepted byte; queue a verdict on the final one
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic bad;
        bad = 1'b0;
        if (seq_pend == 2'd0) begin
            if (b < ASCII_TOP) begin
                if (b < PRINT_MIN || b == ASCII_DEL)
                    seq_err = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                seq_pend = 2'd1;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                seq_pend = 2'd2;
                if (b == LEAD3_MIN)
                    seq_bound = BOUND_MIN_A0;
                else if (b == LEAD3_SURR)
                    seq_bound = BOUND_BELOW_A0;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                seq_pend = 2'd3;
                if (b == LEAD4_MIN)
                    seq_bound = BOUND_MIN_90;
                else if (b == LEAD4_MAX)
                    seq_bound = BOUND_BELOW_90;
            end else begin
                seq_err = 1'b1;
            end
        end else begin
            case (seq_bound)
                BOUND_MIN_A0:   bad = b < CONT_A0;
                BOUND_BELOW_A0: bad = b >= CONT_A0;
                BOUND_MIN_90:   bad = b < CONT_90;
                BOUND_BELOW_90: bad = b >= CONT_90;
                default:        bad = 1'b0;
            endcase
            seq_bound = BOUND_NONE;
            if ((b & CONT_MASK) != CONT_PATTERN)
                bad = 1'b1;
            if (bad)
                seq_err = 1'b1;
            seq_pend = seq_pend - 2'd1;
        end
        if (last) begin
            verdict_q.push_back(!seq_err && seq_pend == 2'd0);
            if (!seq_err && seq_pend == 2'd0)
                good_texts++;
            seq_pend  = '0;
            seq_bound = BOUND_NONE;
            seq_err   = 1'b0;
        end
    endtask

    task automatic put_text(input text_t txt);
        foreach (txt[i])
            pending_bytes.push_back('{data: txt[i], last: (i == txt.size() - 1)});
    endtask

    // sender side
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                track_byte(pending_bytes[0].data, pending_bytes[0].last);
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                go = (pending_bytes.size() != 0) && !take_break();
                s_tvalid <= go;
                if (go) begin
                    s_tdata <= pending_bytes[0].data;
                    s_tlast <= pending_bytes[0].last;
                end
            end
        end
    end

    // receiver side
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict beat with none expected, got %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    if (m_tdata[0] !== verdict_q[0]) begin
                        $display("%0t: text_valid expected %b, got %b",
                                 $time, verdict_q[0], m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        $display("%0t: tdata padding expected 00, got %h",
                                 $time, m_tdata[7:1]);
                        mismatches++;
                    end
                    void'(verdict_q.pop_front());
                end
            end
            m_tready <= !take_break();
        end
    end

    // watchdog: stop if work is outstanding and nothing moves
    always @(posedge clk) begin
        if (rst_n) begin
            cyc <= cyc + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pending_bytes.size() == 0 && verdict_q.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("%0t: no progress for %0d cycles, %0d bytes and %0d verdicts open",
                         $time, StallLimit, pending_bytes.size(), verdict_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        text_t       txt;
        int unsigned total;
        int unsigned kind;
        int unsigned nchar;
        int unsigned pos;
        logic [7:0]  lead;

        // single bytes: printable edges, space, NUL, DEL, stray continuation, never-lead
        put_text('{8'h21});
        put_text('{8'h7E});
        put_text('{8'h20});
        put_text('{8'h00});
        put_text('{8'h7F});
        put_text('{8'h80});
        put_text('{8'hFF});
        // two-byte lead, and an overlong lead
        put_text('{8'hC2, 8'h80});
        put_text('{8'hC1, 8'hBF});
        // overlong and surrogate bounds after E0 / ED
        put_text('{8'hE0, 8'hA0, 8'h80});
        put_text('{8'hE0, 8'h9F, 8'hBF});
        put_text('{8'hED, 8'hA0, 8'h80});
        // bounds after F0 / F4
        put_text('{8'hF0, 8'h8F, 8'hBF, 8'hBF});
        put_text('{8'hF4, 8'h90, 8'h80, 8'h80});
        // sequence cut short by the end of the text
        put_text('{8'hF4});
        // bad continuation, then printable bytes that must not clear the error
        put_text('{8'hC2, 8'h41, 8'h21});

        total = pending_bytes.size();
        while (total < NumBytes) begin
            txt  = {};
            kind = $urandom_range(99);
            if (kind < 15) begin
                // noise: any byte values
                nchar = $urandom_range(1, 6);
                repeat (nchar)
                    txt.push_back(8'($urandom_range(255)));
            end else begin
                nchar = $urandom_range(1, 6);
                repeat (nchar) begin
                    case ($urandom_range(3))
                        0: txt.push_back(8'($urandom_range(8'h21, 8'h7E)));
                        1: begin
                            txt.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
                            txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        2: begin
                            lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
                            txt.push_back(lead);
                            if (lead == LEAD3_MIN)
                                txt.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                            else if (lead == LEAD3_SURR)
                                txt.push_back(8'($urandom_range(8'h80, 8'h9F)));
                            else
                                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                        default: begin
                            lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
                            txt.push_back(lead);
                            if (lead == LEAD4_MIN)
                                txt.push_back(8'($urandom_range(8'h90, 8'hBF)));
                            else if (lead == LEAD4_MAX)
                                txt.push_back(8'($urandom_range(8'h80, 8'h8F)));
                            else
                                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            repeat (2)
                                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end
                    endcase
                end
                // some well-formed texts get one byte spoilt or their tail cut off
                if (kind < 30) begin
                    pos = $urandom_range(txt.size() - 1);
                    txt[pos] = 8'($urandom_range(255));
                end else if (kind < 38 && txt.size() > 1) begin
                    void'(txt.pop_back());
                end
            end
            put_text(txt);
            total += txt.size();
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (Drain) @(posedge clk);

        $display("Sent %0d text bytes; checked %0d verdicts, %0d of them on valid texts.",
                 bytes_sent, verdicts_seen, good_texts);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
